// ===== rtl/gpg_pkg.sv =====
package gpg_pkg;

   localparam int DEF_MAX_BANDS = 16;
   localparam int DEF_SPAN_BITS = 8;

   localparam int COLOR_W = 32;
   localparam int RGB_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int POS_W   = 20;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_EMIT    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BANDS  = 2'd2;

endpackage

// ===== rtl/gradient_palette_generator.sv =====
// Gradient palette generator. Write requests load band entries (colour, width, flat or linear
// mode) into a band memory with one write and one registered read port; emit requests return
// the palette one entry per request, the cursor wrapping after the last entry, and restart
// requests put the cursor back at entry zero. Write, restart and unused requests are handled in
// the cycle in which they are accepted. An emit then reads and checks each band probed while
// the cursor looks for its band (one memory read each, zero-width bands probed the same way),
// then reads and checks each band scanned after a band's final entry to decide whether it is
// the last palette entry, and then emits a flat entry directly or, for a linear one, reads the
// next band and runs the blend unit, an eight-step shift-add multiply and an eight-step
// restoring divide on all three channels together. The request side stalls while an emit is
// in progress; a finished entry waits in the output register without blocking the next
// request, and an emit that finishes while that register is still held waits for it. The
// band memory is not cleared: entries must be written before the palette reaches them. The
// user must write configuration only while the block is idle; the block does not enforce it.
module gradient_palette_generator #(
   parameter int MAX_BANDS = gpg_pkg::DEF_MAX_BANDS,
   parameter int SPAN_BITS = gpg_pkg::DEF_SPAN_BITS
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_opcode,
   input  logic [3:0]                       req_band_slot,
   input  logic [gpg_pkg::COLOR_W-1:0]      req_band_rgb,
   input  logic [7:0]                       req_band_span,
   input  logic                             req_band_blend,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [gpg_pkg::COLOR_W-1:0]      rsp_entry_color,
   output logic [gpg_pkg::POS_W-1:0]        rsp_entry_position,
   output logic                             rsp_last_entry,

   input  logic                             csr_wr_en,
   input  logic [gpg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gpg_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int AW = $clog2(MAX_BANDS);
   localparam int NW = $clog2(MAX_BANDS + 1);
   localparam int TW = $clog2(MAX_BANDS + 3);
   localparam int LW = SPAN_BITS + 8;
   localparam int CW = gpg_pkg::COLOR_W;
   localparam int EW = CW + SPAN_BITS + 1;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_FIND_RD  = 4'd1;
   localparam logic [3:0] ST_FIND_CHK = 4'd2;
   localparam logic [3:0] ST_LAST_RD  = 4'd3;
   localparam logic [3:0] ST_LAST_CHK = 4'd4;
   localparam logic [3:0] ST_COLOR    = 4'd5;
   localparam logic [3:0] ST_NEXT_RD  = 4'd6;
   localparam logic [3:0] ST_NEXT_CHK = 4'd7;
   localparam logic [3:0] ST_BLEND    = 4'd8;
   localparam logic [3:0] ST_EMIT     = 4'd9;

   logic [3:0]                 state_ff, state_in;
   logic                       repeat_ff, repeat_in;
   logic [7:0]                 scale_ff, scale_in;
   logic [4:0]                 bands_ff, bands_in;
   logic [NW-1:0]              cb_ff, cb_in;
   logic [LW-1:0]              off_ff, off_in;
   logic [gpg_pkg::POS_W-1:0]  cnt_ff, cnt_in;
   logic [TW-1:0]              tries_ff, tries_in;
   logic [NW-1:0]              sb_ff, sb_in;
   logic [CW-1:0]              c1_ff, c1_in;
   logic                       mode_ff, mode_in;
   logic [LW-1:0]              len_ff, len_in;
   logic                       tail_ff, tail_in;
   logic                       last_ff, last_in;
   logic [CW-1:0]              color_ff, color_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]              rsp_color_ff, rsp_color_in;
   logic [gpg_pkg::POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [EW-1:0]              band_mem [MAX_BANDS];
   logic [EW-1:0]              rd_data_ff;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              wr_addr;
   logic [EW-1:0]              wr_data;
   logic                       mem_we;

   logic                       req_accept;
   logic                       out_free;
   logic [NW-1:0]              n_c;
   logic [NW-1:0]              n_m1;
   logic [NW-1:0]              cb_nx;
   logic                       cb_nx_ok;
   logic [NW-1:0]              chk_idx;
   logic                       chk_tail;
   logic [LW-1:0]              len_c;
   logic [CW-1:0]              rd_color;
   logic [SPAN_BITS-1:0]       rd_width;
   logic                       rd_mode;
   logic [SPAN_BITS+7:0]       span_wide;
   logic [AW+3:0]              slot_wide;
   logic                       slot_ok;
   logic                       blend_start;
   logic                       blend_done;
   logic [gpg_pkg::RGB_W-1:0]  blend_rgb;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // bands in use, zero acts as one, clamped to the table depth
   always_comb begin
      if (bands_ff == 5'd0) begin
         n_c = NW'(1);
      end else if (32'(bands_ff) > MAX_BANDS) begin
         n_c = NW'(MAX_BANDS);
      end else begin
         n_c = NW'(bands_ff);
      end
   end

   assign n_m1     = n_c - NW'(1);
   assign cb_nx    = cb_ff + NW'(1);
   assign cb_nx_ok = ({1'b0, cb_ff} + (NW+1)'(1)) < {1'b0, n_c};

   assign rd_color = rd_data_ff[CW-1:0];
   assign rd_width = rd_data_ff[CW+SPAN_BITS-1:CW];
   assign rd_mode  = rd_data_ff[EW-1];

   // band length: the final band with repeat off gives one entry
   assign chk_idx  = (state_ff == ST_LAST_CHK) ? sb_ff : cb_ff;
   assign chk_tail = !repeat_ff && (chk_idx == n_m1);
   assign len_c    = chk_tail ? LW'(1) : (LW'(rd_width) * LW'(scale_ff));

   assign span_wide = {SPAN_BITS'(0), req_band_span};
   assign slot_wide = {AW'(0), req_band_slot};
   assign slot_ok   = (32'(req_band_slot) < MAX_BANDS);
   assign wr_addr   = slot_wide[AW-1:0];
   assign wr_data   = {req_band_blend, span_wide[SPAN_BITS-1:0], req_band_rgb};

   always_comb begin
      case (state_ff)
         ST_FIND_RD: rd_addr = (cb_ff >= n_c) ? AW'(0) : cb_ff[AW-1:0];
         ST_LAST_RD: rd_addr = sb_ff[AW-1:0];
         ST_NEXT_RD: rd_addr = cb_nx_ok ? cb_nx[AW-1:0] : AW'(0);
         default:    rd_addr = cb_ff[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         band_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= band_mem[rd_addr];
   end

   gpg_blend #(
      .LEN_W (LW)
   ) u_blend (
      .clock (clock),
      .reset (reset),
      .start (blend_start),
      .c1    (c1_ff[gpg_pkg::RGB_W-1:0]),
      .c2    (rd_color[gpg_pkg::RGB_W-1:0]),
      .pos   (off_ff),
      .span  (len_ff),
      .done  (blend_done),
      .rgb   (blend_rgb)
   );

   always_comb begin
      state_in     = state_ff;
      repeat_in    = repeat_ff;
      scale_in     = scale_ff;
      bands_in     = bands_ff;
      cb_in        = cb_ff;
      off_in       = off_ff;
      cnt_in       = cnt_ff;
      tries_in     = tries_ff;
      sb_in        = sb_ff;
      c1_in        = c1_ff;
      mode_in      = mode_ff;
      len_in       = len_ff;
      tail_in      = tail_ff;
      last_in      = last_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_color_in = rsp_color_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      blend_start  = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            gpg_pkg::CSR_REPEAT: repeat_in = csr_wr_data[0];
            gpg_pkg::CSR_SCALE:  scale_in  = csr_wr_data[7:0];
            gpg_pkg::CSR_BANDS:  bands_in  = csr_wr_data[4:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  gpg_pkg::OP_WRITE: begin
                     mem_we = slot_ok;
                  end
                  gpg_pkg::OP_EMIT: begin
                     tries_in = '0;
                     state_in = ST_FIND_RD;
                  end
                  gpg_pkg::OP_RESTART: begin
                     cb_in  = '0;
                     off_in = '0;
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIND_RD: begin
            if (cb_ff >= n_c) begin
               cb_in  = '0;
               off_in = '0;
               cnt_in = '0;
            end
            state_in = ST_FIND_CHK;
         end
         ST_FIND_CHK: begin
            if (off_ff < len_c) begin
               c1_in   = rd_color;
               mode_in = rd_mode;
               len_in  = len_c;
               tail_in = chk_tail;
               if (((LW+1)'(off_ff) + (LW+1)'(1)) == {1'b0, len_c}) begin
                  if (cb_nx_ok) begin
                     sb_in    = cb_nx;
                     state_in = ST_LAST_RD;
                  end else begin
                     last_in  = 1'b1;
                     state_in = ST_COLOR;
                  end
               end else begin
                  last_in  = 1'b0;
                  state_in = ST_COLOR;
               end
            end else begin
               cb_in  = cb_nx;
               off_in = '0;
               if (tries_ff == (TW'(n_c) + TW'(1))) begin
                  // nothing to emit
                  cb_in    = '0;
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  tries_in = tries_ff + TW'(1);
                  state_in = ST_FIND_RD;
               end
            end
         end
         ST_LAST_RD: begin
            state_in = ST_LAST_CHK;
         end
         ST_LAST_CHK: begin
            if (len_c != '0) begin
               last_in  = 1'b0;
               state_in = ST_COLOR;
            end else if (({1'b0, sb_ff} + (NW+1)'(1)) < {1'b0, n_c}) begin
               sb_in    = sb_ff + NW'(1);
               state_in = ST_LAST_RD;
            end else begin
               last_in  = 1'b1;
               state_in = ST_COLOR;
            end
         end
         ST_COLOR: begin
            if (tail_ff || !mode_ff) begin
               color_in = c1_ff;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_NEXT_RD;
            end
         end
         ST_NEXT_RD: begin
            state_in = ST_NEXT_CHK;
         end
         ST_NEXT_CHK: begin
            blend_start = 1'b1;
            state_in    = ST_BLEND;
         end
         ST_BLEND: begin
            if (blend_done) begin
               color_in = {gpg_pkg::ALPHA_OPAQUE, blend_rgb};
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = color_ff;
               rsp_pos_in   = cnt_ff;
               rsp_last_in  = last_ff;
               if (last_ff) begin
                  cb_in  = '0;
                  off_in = '0;
                  cnt_in = '0;
               end else begin
                  off_in = off_ff + LW'(1);
                  cnt_in = cnt_ff + gpg_pkg::POS_W'(1);
                  if (((LW+1)'(off_ff) + (LW+1)'(1)) >= {1'b0, len_ff}) begin
                     cb_in  = cb_nx;
                     off_in = '0;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         repeat_ff    <= 1'b0;
         scale_ff     <= 8'd1;
         bands_ff     <= 5'd1;
         cb_ff        <= '0;
         off_ff       <= '0;
         cnt_ff       <= '0;
         tries_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         repeat_ff    <= repeat_in;
         scale_ff     <= scale_in;
         bands_ff     <= bands_in;
         cb_ff        <= cb_in;
         off_ff       <= off_in;
         cnt_ff       <= cnt_in;
         tries_ff     <= tries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sb_ff        <= sb_in;
      c1_ff        <= c1_in;
      mode_ff      <= mode_in;
      len_ff       <= len_in;
      tail_ff      <= tail_in;
      last_ff      <= last_in;
      color_ff     <= color_in;
      rsp_color_ff <= rsp_color_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_color    = rsp_color_ff;
   assign rsp_entry_position = rsp_pos_ff;
   assign rsp_last_entry     = rsp_last_ff;

endmodule

// ===== rtl/gpg_blend.sv =====
module gpg_blend #(
   parameter int LEN_W = gpg_pkg::DEF_SPAN_BITS + 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gpg_pkg::RGB_W-1:0]   c1,
   input  logic [gpg_pkg::RGB_W-1:0]   c2,
   input  logic [LEN_W-1:0]            pos,
   input  logic [LEN_W-1:0]            span,
   output logic                        done,
   output logic [gpg_pkg::RGB_W-1:0]   rgb
);

   localparam int ACC_W = LEN_W + gpg_pkg::CHAN_W;
   localparam int DIV_W = LEN_W + 10;
   localparam int NCH   = gpg_pkg::RGB_W / gpg_pkg::CHAN_W;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_LOAD = 2'd2;
   localparam logic [1:0] PH_DIV  = 2'd3;

   logic [1:0]                  phase_ff, phase_in;
   logic [2:0]                  step_ff, step_in;
   logic                        done_ff, done_in;
   logic [LEN_W-1:0]            wmi_ff, wmi_in;
   logic [LEN_W-1:0]            pos_ff, pos_in;
   logic [LEN_W-1:0]            span_ff, span_in;
   logic [gpg_pkg::RGB_W-1:0]   c1_ff, c1_in;
   logic [gpg_pkg::RGB_W-1:0]   c2_ff, c2_in;
   logic [ACC_W-1:0]            acc_ff [NCH];
   logic [ACC_W-1:0]            acc_in [NCH];
   logic [DIV_W-1:0]            rem_ff [NCH];
   logic [DIV_W-1:0]            rem_in [NCH];
   logic [gpg_pkg::CHAN_W-1:0]  q_ff [NCH];
   logic [gpg_pkg::CHAN_W-1:0]  q_in [NCH];
   logic [DIV_W-1:0]            dv_ff, dv_in;

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      wmi_in   = wmi_ff;
      pos_in   = pos_ff;
      span_in  = span_ff;
      c1_in    = c1_ff;
      c2_in    = c2_ff;
      dv_in    = dv_ff;
      for (int ch = 0; ch < NCH; ch++) begin
         acc_in[ch] = acc_ff[ch];
         rem_in[ch] = rem_ff[ch];
         q_in[ch]   = q_ff[ch];
      end
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               wmi_in   = span - pos;
               pos_in   = pos;
               span_in  = span;
               c1_in    = c1;
               c2_in    = c2;
               step_in  = 3'd7;
               phase_in = PH_MUL;
               for (int ch = 0; ch < NCH; ch++) begin
                  acc_in[ch] = '0;
               end
            end
         end
         PH_MUL: begin
            // shift-add of c1*(w-i) + c2*i, msb first
            for (int ch = 0; ch < NCH; ch++) begin
               acc_in[ch] = (acc_ff[ch] << 1)
                  + (c1_ff[gpg_pkg::CHAN_W*ch + int'(step_ff)] ? ACC_W'(wmi_ff) : '0)
                  + (c2_ff[gpg_pkg::CHAN_W*ch + int'(step_ff)] ? ACC_W'(pos_ff) : '0);
            end
            if (step_ff == 3'd0) begin
               phase_in = PH_LOAD;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         PH_LOAD: begin
            // round half up: (2*num + w) / (2*w)
            for (int ch = 0; ch < NCH; ch++) begin
               rem_in[ch] = DIV_W'({acc_ff[ch], 1'b0}) + DIV_W'(span_ff);
               q_in[ch]   = '0;
            end
            dv_in    = DIV_W'(span_ff) << 8;
            step_in  = 3'd7;
            phase_in = PH_DIV;
         end
         PH_DIV: begin
            for (int ch = 0; ch < NCH; ch++) begin
               if (rem_ff[ch] >= dv_ff) begin
                  rem_in[ch] = rem_ff[ch] - dv_ff;
                  q_in[ch]   = {q_ff[ch][gpg_pkg::CHAN_W-2:0], 1'b1};
               end else begin
                  q_in[ch]   = {q_ff[ch][gpg_pkg::CHAN_W-2:0], 1'b0};
               end
            end
            dv_in = dv_ff >> 1;
            if (step_ff == 3'd0) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      wmi_ff  <= wmi_in;
      pos_ff  <= pos_in;
      span_ff <= span_in;
      c1_ff   <= c1_in;
      c2_ff   <= c2_in;
      dv_ff   <= dv_in;
      for (int ch = 0; ch < NCH; ch++) begin
         acc_ff[ch] <= acc_in[ch];
         rem_ff[ch] <= rem_in[ch];
         q_ff[ch]   <= q_in[ch];
      end
   end

   assign done = done_ff;
   assign rgb  = {q_ff[2], q_ff[1], q_ff[0]};

endmodule
